[src/m61h_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61h_pkg: shared types and helpers for the mod 2^61-1 rolling hash engine
// Field widths, op codes, queue item layout and the Mersenne reduction.
// ----------------------------------------------------------------------------
package m61h_pkg;

  localparam int IDX_W       = 11;
  localparam int HW          = 61;
  localparam int MAX_LEN_DEF = 1024;
  localparam logic [HW-1:0] MOD61    = 61'h1fff_ffff_ffff_ffff;
  localparam logic [HW-1:0] BASE_RST = 61'd131;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_RANGE  = 3'd2,
    OP_JOIN   = 3'd3,
    OP_LCP    = 3'd4
  } op_e;

  // Classified item as it travels from front to back.
  // n: table index for append, shorter range length for common prefix.
  typedef struct packed {
    op_e              op;
    logic             err;
    logic [7:0]       ch;
    logic [IDX_W-1:0] sa;
    logic [IDX_W-1:0] ea;
    logic [IDX_W-1:0] sb;
    logic [IDX_W-1:0] lb;
    logic [IDX_W-1:0] n;
    logic [HW-1:0]    ha;
    logic [HW-1:0]    hb;
  } item_t;

  // Fold a value below 2^62 into [0, P).
  function automatic logic [HW-1:0] reduce62(input logic [HW:0] x);
    logic [HW:0] s;
    s = {1'b0, x[HW-1:0]} + {{HW{1'b0}}, x[HW]};
    if (s >= {1'b0, MOD61}) begin
      s = s - {1'b0, MOD61};
    end
    return s[HW-1:0];
  endfunction

endpackage

[src/m61h_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61h_queue: two-entry item queue
// Decouples the classifying front from the executing back.
// ----------------------------------------------------------------------------
module m61h_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  m61h_pkg::item_t push_item_i,
  input  logic            pop_i,
  output m61h_pkg::item_t pop_item_o,
  output logic            full_o,
  output logic            empty_o
);

  m61h_pkg::item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[src/m61h_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61h_front: command intake and classification
// Tracks the stored length, checks ranges and flags rejected commands.
// ----------------------------------------------------------------------------
module m61h_front #(
  parameter int MAX_LEN = m61h_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       full_i,
  input  logic [2:0]                 op_i,
  input  logic [7:0]                 char_in_i,
  input  logic [m61h_pkg::IDX_W-1:0] start_a_i,
  input  logic [m61h_pkg::IDX_W-1:0] end_a_i,
  input  logic [m61h_pkg::IDX_W-1:0] start_b_i,
  input  logic [m61h_pkg::IDX_W-1:0] end_b_i,
  input  logic [m61h_pkg::HW-1:0]    hash_a_i,
  input  logic [m61h_pkg::HW-1:0]    hash_b_i,
  input  logic [m61h_pkg::IDX_W-1:0] length_b_i,
  output logic                       push_o,
  output m61h_pkg::item_t            item_o
);

  localparam logic [m61h_pkg::IDX_W-1:0] LenMax = m61h_pkg::IDX_W'(MAX_LEN);

  logic [m61h_pkg::IDX_W-1:0] len_q, len_d;
  logic [m61h_pkg::IDX_W-1:0] da, db;
  logic ok_a, ok_b;

  assign push_o = start_i && !full_i;
  assign ok_a   = (start_a_i <= end_a_i) && (end_a_i <= len_q);
  assign ok_b   = (start_b_i <= end_b_i) && (end_b_i <= len_q);
  assign da     = end_a_i - start_a_i;
  assign db     = end_b_i - start_b_i;

  always_comb begin
    item_o    = '0;
    item_o.op = m61h_pkg::op_e'(op_i);
    item_o.ch = char_in_i;
    item_o.sa = start_a_i;
    item_o.ea = end_a_i;
    item_o.sb = start_b_i;
    item_o.lb = length_b_i;
    item_o.ha = hash_a_i;
    item_o.hb = hash_b_i;
    item_o.n  = len_q;
    len_d     = len_q;
    unique case (op_i)
      m61h_pkg::OP_CLEAR: begin
        len_d = '0;
      end
      m61h_pkg::OP_APPEND: begin
        if (len_q >= LenMax) begin
          item_o.err = 1'b1;
        end else begin
          len_d = len_q + 1'b1;
        end
      end
      m61h_pkg::OP_RANGE: begin
        item_o.err = !ok_a;
      end
      m61h_pkg::OP_JOIN: begin
        item_o.err = (length_b_i > len_q);
      end
      m61h_pkg::OP_LCP: begin
        item_o.err = !(ok_a && ok_b);
        item_o.n   = (da < db) ? da : db;
      end
      default: begin
        item_o.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (push_o) begin
      len_q <= len_d;
    end
  end

endmodule

[src/m61h_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61h_mul: sequential 61x61 multiply modulo 2^61-1
// One 32x32 partial product per cycle, then a fold step and a reduction step.
// ----------------------------------------------------------------------------
module m61h_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [m61h_pkg::HW-1:0] a_i,
  input  logic [m61h_pkg::HW-1:0] b_i,
  output logic                    done_o,
  output logic [m61h_pkg::HW-1:0] res_o
);

  logic                    run_q;
  logic [2:0]              cnt_q;
  logic                    done_q;
  logic [m61h_pkg::HW-1:0] a_q, b_q, res_q;
  logic [121:0]            acc_q;
  logic [m61h_pkg::HW:0]   fold_q;
  logic [31:0]             al, bl;
  logic [63:0]             pp;
  logic [121:0]            addend;

  assign al = cnt_q[1] ? {3'b0, a_q[60:32]} : a_q[31:0];
  assign bl = cnt_q[0] ? {3'b0, b_q[60:32]} : b_q[31:0];
  assign pp = al * bl;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    addend = {58'b0, pp};
      2'd3:    addend = {pp[57:0], 64'b0};
      default: addend = {26'b0, pp, 32'b0};
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 3'd5) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (!cnt_q[2]) begin
        acc_q <= acc_q + addend;
      end else if (cnt_q == 3'd4) begin
        fold_q <= {1'b0, acc_q[121:61]} + {1'b0, acc_q[60:0]};
      end else begin
        res_q <= m61h_pkg::reduce62(fold_q);
      end
    end
  end

endmodule

[src/m61h_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61h_back: command execution
// Owns the prefix-hash and power tables, sequences table reads, the
// modular multiplier and the binary search for common prefixes.
// ----------------------------------------------------------------------------
module m61h_back #(
  parameter int MAX_LEN = m61h_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  m61h_pkg::item_t            item_i,
  output logic                       pop_o,
  input  logic [m61h_pkg::HW-1:0]    base_i,
  output logic                       res_valid_o,
  output logic [m61h_pkg::HW-1:0]    hash_o,
  output logic [m61h_pkg::IDX_W-1:0] plen_o,
  output logic                       err_o
);

  localparam int IW = m61h_pkg::IDX_W;
  localparam int HW = m61h_pkg::HW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_AP_RD = 4'd1;
  localparam logic [3:0] ST_AP_M1 = 4'd2;
  localparam logic [3:0] ST_AP_W1 = 4'd3;
  localparam logic [3:0] ST_AP_W2 = 4'd4;
  localparam logic [3:0] ST_RH_A  = 4'd5;
  localparam logic [3:0] ST_RH_B  = 4'd6;
  localparam logic [3:0] ST_RH_C  = 4'd7;
  localparam logic [3:0] ST_RH_W  = 4'd8;
  localparam logic [3:0] ST_JN_RD = 4'd9;
  localparam logic [3:0] ST_JN_M  = 4'd10;
  localparam logic [3:0] ST_JN_W  = 4'd11;
  localparam logic [3:0] ST_LCP   = 4'd12;

  logic [HW-1:0] ph_mem [MAX_LEN+1];
  logic [HW-1:0] pw_mem [MAX_LEN+1];

  logic [3:0]      state_q, state_d;
  m61h_pkg::item_t it_q, it_d;
  logic [IW-1:0]   rl_q, rl_d, rr_q, rr_d;
  logic [IW-1:0]   low_q, low_d, high_q, high_d, mid_q, mid_d;
  logic            phase_q, phase_d;
  logic [HW-1:0]   hsa_q, hsa_d, prr_q, prr_d, phn_q, phn_d;
  logic            vld_q, vld_d, err_q, err_d;
  logic [HW-1:0]   hash_q, hash_d;
  logic [IW-1:0]   plen_q, plen_d;

  logic [IW-1:0] p_raddr, w_raddr;
  logic [HW-1:0] p_rd_q, w_rd_q, p_data, w_data;
  logic          p_zero_q, w_zero_q;
  logic          pw_we, ph_we;
  logic [HW-1:0] ph_wdata;

  logic          mul_start, mul_done;
  logic [HW-1:0] mul_a, mul_b, mul_res;
  logic [HW-1:0] rh;
  logic [IW:0]   mid_sum;

  m61h_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // entry zero of each table is supplied by logic and never written
  assign p_data = p_zero_q ? '0 : p_rd_q;
  assign w_data = w_zero_q ? HW'(1) : w_rd_q;

  assign rh       = m61h_pkg::reduce62({1'b0, prr_q} + {1'b0, m61h_pkg::MOD61 - mul_res});
  assign ph_wdata = m61h_pkg::reduce62({1'b0, mul_res} + {{(HW-7){1'b0}}, it_q.ch});
  assign mid_sum  = {1'b0, low_q} + {1'b0, high_q};

  always_ff @(posedge clk_i) begin
    p_rd_q   <= ph_mem[p_raddr];
    w_rd_q   <= pw_mem[w_raddr];
    p_zero_q <= (p_raddr == '0);
    w_zero_q <= (w_raddr == '0);
    if (pw_we) begin
      pw_mem[it_q.n + 1'b1] <= mul_res;
    end
    if (ph_we) begin
      ph_mem[it_q.n + 1'b1] <= ph_wdata;
    end
  end

  always_comb begin
    state_d   = state_q;
    it_d      = it_q;
    rl_d      = rl_q;
    rr_d      = rr_q;
    low_d     = low_q;
    high_d    = high_q;
    mid_d     = mid_q;
    phase_d   = phase_q;
    hsa_d     = hsa_q;
    prr_d     = prr_q;
    phn_d     = phn_q;
    vld_d     = 1'b0;
    err_d     = err_q;
    hash_d    = hash_q;
    plen_d    = plen_q;
    pop_o     = 1'b0;
    p_raddr   = '0;
    w_raddr   = '0;
    pw_we     = 1'b0;
    ph_we     = 1'b0;
    mul_start = 1'b0;
    mul_a     = w_data;
    mul_b     = base_i;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          it_d   = item_i;
          err_d  = 1'b0;
          hash_d = '0;
          plen_d = '0;
          if (item_i.err) begin
            vld_d = 1'b1;
            err_d = 1'b1;
          end else begin
            unique case (item_i.op)
              m61h_pkg::OP_APPEND: state_d = ST_AP_RD;
              m61h_pkg::OP_RANGE: begin
                rl_d    = item_i.sa;
                rr_d    = item_i.ea;
                state_d = ST_RH_A;
              end
              m61h_pkg::OP_JOIN: state_d = ST_JN_RD;
              m61h_pkg::OP_LCP: begin
                low_d   = '0;
                high_d  = item_i.n + 1'b1;
                state_d = ST_LCP;
              end
              default: vld_d = 1'b1;  // clear: all-zero result
            endcase
          end
        end
      end
      ST_AP_RD: begin
        p_raddr = it_q.n;
        w_raddr = it_q.n;
        state_d = ST_AP_M1;
      end
      ST_AP_M1: begin
        phn_d     = p_data;
        mul_start = 1'b1;
        state_d   = ST_AP_W1;
      end
      ST_AP_W1: begin
        if (mul_done) begin
          pw_we     = 1'b1;
          mul_a     = phn_q;
          mul_start = 1'b1;
          state_d   = ST_AP_W2;
        end
      end
      ST_AP_W2: begin
        if (mul_done) begin
          ph_we   = 1'b1;
          vld_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RH_A: begin
        p_raddr = rl_q;
        w_raddr = rr_q - rl_q;
        state_d = ST_RH_B;
      end
      ST_RH_B: begin
        p_raddr   = rr_q;
        mul_a     = p_data;
        mul_b     = w_data;
        mul_start = 1'b1;
        state_d   = ST_RH_C;
      end
      ST_RH_C: begin
        prr_d   = p_data;
        state_d = ST_RH_W;
      end
      ST_RH_W: begin
        if (mul_done) begin
          if (it_q.op == m61h_pkg::OP_RANGE) begin
            hash_d  = rh;
            vld_d   = 1'b1;
            state_d = ST_IDLE;
          end else if (!phase_q) begin
            hsa_d   = rh;
            rl_d    = it_q.sb;
            rr_d    = it_q.sb + mid_q;
            phase_d = 1'b1;
            state_d = ST_RH_A;
          end else begin
            if (hsa_q == rh) begin
              low_d = mid_q;
            end else begin
              high_d = mid_q;
            end
            state_d = ST_LCP;
          end
        end
      end
      ST_JN_RD: begin
        w_raddr = it_q.lb;
        state_d = ST_JN_M;
      end
      ST_JN_M: begin
        mul_a     = it_q.ha;
        mul_b     = w_data;
        mul_start = 1'b1;
        state_d   = ST_JN_W;
      end
      ST_JN_W: begin
        if (mul_done) begin
          hash_d  = m61h_pkg::reduce62({1'b0, mul_res} +
                    {1'b0, (it_q.hb == m61h_pkg::MOD61) ? {HW{1'b0}} : it_q.hb});
          vld_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LCP: begin
        if (high_q - low_q > IW'(1)) begin
          mid_d   = mid_sum[IW:1];
          rl_d    = it_q.sa;
          rr_d    = it_q.sa + mid_sum[IW:1];
          phase_d = 1'b0;
          state_d = ST_RH_A;
        end else begin
          plen_d  = low_q;
          vld_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    rl_q    <= rl_d;
    rr_q    <= rr_d;
    low_q   <= low_d;
    high_q  <= high_d;
    mid_q   <= mid_d;
    phase_q <= phase_d;
    hsa_q   <= hsa_d;
    prr_q   <= prr_d;
    phn_q   <= phn_d;
    err_q   <= err_d;
    hash_q  <= hash_d;
    plen_q  <= plen_d;
  end

  assign res_valid_o = vld_q;
  assign hash_o      = hash_q;
  assign plen_o      = plen_q;
  assign err_o       = err_q;

endmodule

[src/mersenne61_rolling_hash_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne61_rolling_hash_engine: polynomial rolling hash modulo 2^61-1
// Builds a byte string with prefix-hash and power tables and answers range
// hash, hash join and longest-common-prefix commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers on a clock edge with start high and busy low. busy
//   rises only while the two-entry command queue is full, so a caller may
//   issue several commands back to back while earlier ones execute.
//   Each command produces exactly one result, shown for one cycle with
//   res_valid_o high, in command order. The receiver cannot stall it. The
//   caller must write hash_base through cfg_we_i / cfg_wdata_i only while
//   idle; the block itself does not enforce this.
// An append runs two multiplies in series. A common-prefix command runs a
// binary search of at most ceil(log2(len+1)) steps, one range-hash pair
// each. The back end runs one command at a time while later ones wait in
// the queue.
// Reset: stored length 0, hash_base 131, queue empty. Tables need no
// clearing pass: entry zero of each table is supplied by logic.
// ----------------------------------------------------------------------------
module mersenne61_rolling_hash_engine #(
  parameter int MAX_LEN = m61h_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 op_i,
  input  logic [7:0]                 char_in_i,
  input  logic [m61h_pkg::IDX_W-1:0] start_a_i,
  input  logic [m61h_pkg::IDX_W-1:0] end_a_i,
  input  logic [m61h_pkg::IDX_W-1:0] start_b_i,
  input  logic [m61h_pkg::IDX_W-1:0] end_b_i,
  input  logic [m61h_pkg::HW-1:0]    hash_a_i,
  input  logic [m61h_pkg::HW-1:0]    hash_b_i,
  input  logic [m61h_pkg::IDX_W-1:0] length_b_i,
  input  logic                       cfg_we_i,
  input  logic [m61h_pkg::HW-1:0]    cfg_wdata_i,
  output logic                       res_valid_o,
  output logic [m61h_pkg::HW-1:0]    hash_out_o,
  output logic [m61h_pkg::IDX_W-1:0] prefix_len_o,
  output logic                       error_o
);

  logic [m61h_pkg::HW-1:0] base_q;
  logic                    push, pop, full, empty;
  m61h_pkg::item_t         push_item, pop_item;

  // base register; a value equal to P acts as zero inside the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= m61h_pkg::BASE_RST;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  assign busy = full;

  // front: validity checks against the stored length at transfer time
  m61h_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .full_i    (full),
    .op_i      (op_i),
    .char_in_i (char_in_i),
    .start_a_i (start_a_i),
    .end_a_i   (end_a_i),
    .start_b_i (start_b_i),
    .end_b_i   (end_b_i),
    .hash_a_i  (hash_a_i),
    .hash_b_i  (hash_b_i),
    .length_b_i(length_b_i),
    .push_o    (push),
    .item_o    (push_item)
  );

  m61h_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .full_o     (full),
    .empty_o    (empty)
  );

  // back: table memories, multiplier and prefix search
  m61h_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (pop_item),
    .pop_o      (pop),
    .base_i     (base_q),
    .res_valid_o(res_valid_o),
    .hash_o     (hash_out_o),
    .plen_o     (prefix_len_o),
    .err_o      (error_o)
  );

  // rejected commands report nothing but the flag
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && error_o |-> hash_out_o == '0 && prefix_len_o == '0)
    else $error("rejected command carries data");

  // hashes always come out canonical
  a_hash_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> hash_out_o != m61h_pkg::MOD61)
    else $error("hash not reduced");

  // a command never produces both a hash and a prefix length
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && prefix_len_o != '0 |-> hash_out_o == '0)
    else $error("prefix result with hash");

  // a result is never shown with an empty pipeline the cycle before
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(!empty || u_back.state_q != u_back.ST_IDLE))
    else $error("result without command");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the mod 2^61-1 rolling hash engine
// Commands are queued by a stimulus process. A negedge driver issues them
// with random gaps. A posedge monitor keeps its own copy of the hash tables
// and predicts every result, then compares it with the result strobe.
// ----------------------------------------------------------------------------
module tb;

  localparam int            HW        = m61h_pkg::HW;
  localparam int            IDX_W     = m61h_pkg::IDX_W;
  localparam logic [HW-1:0] MOD61     = m61h_pkg::MOD61;
  localparam logic [HW-1:0] BASE_RST  = m61h_pkg::BASE_RST;
  localparam int            STR_CAP   = 1024;
  localparam int            WD_LIMIT  = 20000;
  localparam logic [2:0]    OP_BAD_5  = 3'd5;
  localparam logic [2:0]    OP_BAD_6  = 3'd6;
  localparam logic [2:0]    OP_BAD_7  = 3'd7;
  localparam logic [HW-1:0] BASE_MAX  = MOD61 - 61'd1;

  typedef struct {
    logic [2:0]       op;
    logic [7:0]       ch;
    logic [IDX_W-1:0] sa, ea, sb, eb, lb;
    logic [HW-1:0]    ha, hb;
    int               gap;
  } cmd_t;

  typedef struct {
    logic [HW-1:0]    hsh;
    logic [IDX_W-1:0] plen;
    logic             err;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]       op_i = '0;
  logic [7:0]       char_in_i = '0;
  logic [IDX_W-1:0] start_a_i = '0, end_a_i = '0, start_b_i = '0, end_b_i = '0;
  logic [IDX_W-1:0] length_b_i = '0;
  logic [HW-1:0]    hash_a_i = '0, hash_b_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [HW-1:0]    cfg_wdata_i = '0;
  logic             res_valid_o;
  logic [HW-1:0]    hash_out_o;
  logic [IDX_W-1:0] prefix_len_o;
  logic             error_o;

  mersenne61_rolling_hash_engine dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .char_in_i, .start_a_i, .end_a_i,
    .start_b_i, .end_b_i, .hash_a_i, .hash_b_i, .length_b_i, .cfg_we_i,
    .cfg_wdata_i, .res_valid_o, .hash_out_o, .prefix_len_o, .error_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  bit   xfer_seen = 1'b0;   // command transferred at the last rising edge
  int   fail_cnt = 0;
  int   idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Shadow state of the engine
  // ---------------------------------------------------------------------------
  logic [HW-1:0] shadow_base = BASE_RST;
  logic [HW-1:0] prefix_tab[0:STR_CAP];
  logic [HW-1:0] power_tab[0:STR_CAP];
  int            shadow_len = 0;

  function automatic logic [HW-1:0] fold62(input logic [HW:0] x);
    logic [HW:0] s;
    s = {1'b0, x[HW-1:0]} + {{HW{1'b0}}, x[HW]};
    if (s >= {1'b0, MOD61}) s = s - {1'b0, MOD61};
    return s[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] mul_p61(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [2*HW-1:0] prod;
    logic [HW:0]     part;
    prod = {{HW{1'b0}}, a} * {{HW{1'b0}}, b};
    part = {1'b0, prod[2*HW-1:HW]} + {1'b0, prod[HW-1:0]};
    return fold62(part);
  endfunction

  function automatic logic [HW-1:0] span_hash(input int l, input int r);
    logic [HW-1:0] t;
    t = mul_p61(prefix_tab[l], power_tab[r-l]);
    return fold62({1'b0, prefix_tab[r]} + {1'b0, MOD61} - {1'b0, t});
  endfunction

  function automatic bit span_ok(input int l, input int r);
    return l <= r && r <= shadow_len;
  endfunction

  // Applies one command to the shadow state and returns its result.
  function automatic res_t hash_engine_step(input cmd_t c);
    res_t o;
    int sa, ea, sb, eb, lb, lo, hi, mid, len;
    o = '{hsh: '0, plen: '0, err: 1'b0};
    sa = c.sa; ea = c.ea; sb = c.sb; eb = c.eb; lb = c.lb;
    case (c.op)
      m61h_pkg::OP_CLEAR: shadow_len = 0;
      m61h_pkg::OP_APPEND: begin
        if (shadow_len >= STR_CAP) begin
          o.err = 1'b1;
        end else begin
          power_tab[shadow_len+1] = mul_p61(power_tab[shadow_len], shadow_base);
          prefix_tab[shadow_len+1] =
            fold62({1'b0, mul_p61(prefix_tab[shadow_len], shadow_base)} +
                   {{(HW-7){1'b0}}, c.ch});
          shadow_len++;
        end
      end
      m61h_pkg::OP_RANGE: begin
        if (span_ok(sa, ea)) o.hsh = span_hash(sa, ea);
        else o.err = 1'b1;
      end
      m61h_pkg::OP_JOIN: begin
        if (lb <= shadow_len)
          o.hsh = fold62({1'b0, mul_p61(c.ha, power_tab[lb])} + {1'b0, fold62({1'b0, c.hb})});
        else o.err = 1'b1;
      end
      m61h_pkg::OP_LCP: begin
        if (span_ok(sa, ea) && span_ok(sb, eb)) begin
          len = (ea - sa < eb - sb) ? ea - sa : eb - sb;
          lo = 0;
          hi = len + 1;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (span_hash(sa, sa + mid) == span_hash(sb, sb + mid)) lo = mid;
            else hi = mid;
          end
          o.plen = lo[IDX_W-1:0];
        end else begin
          o.err = 1'b1;
        end
      end
      default: o.err = 1'b1;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: result check first, then prediction for a new transfer. A
  // result can never belong to a command transferred on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    cmd_t c;
    bit   activity;
    activity = 1'b0;
    if (rst_ni && res_valid_o) begin
      activity = 1'b1;
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result hash=%h plen=%0d err=%b",
                 $time, hash_out_o, prefix_len_o, error_o);
        fail_cnt++;
      end else begin
        want = expected_res.pop_front();
        if (hash_out_o !== want.hsh) begin
          $display("%0t: hash_out expected %h actual %h", $time, want.hsh, hash_out_o);
          fail_cnt++;
        end
        if (prefix_len_o !== want.plen) begin
          $display("%0t: prefix_len expected %0d actual %0d", $time, want.plen,
                   prefix_len_o);
          fail_cnt++;
        end
        if (error_o !== want.err) begin
          $display("%0t: error expected %b actual %b", $time, want.err, error_o);
          fail_cnt++;
        end
      end
    end
    xfer_seen = rst_ni && start && !busy;
    if (xfer_seen) begin
      activity = 1'b1;
      c.op = op_i; c.ch = char_in_i; c.sa = start_a_i; c.ea = end_a_i;
      c.sb = start_b_i; c.eb = end_b_i; c.ha = hash_a_i; c.hb = hash_b_i;
      c.lb = length_b_i; c.gap = 0;
      expected_res.push_back(hash_engine_step(c));
    end
    // base write only matters for later appends
    if (rst_ni && cfg_we_i) shadow_base = cfg_wdata_i;
    idle_cycles = activity ? 0 : idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: hold a command until it transfers, then wait out its gap
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  always @(negedge clk_i) begin
    cmd_t c;
    if (start && !xfer_seen) begin
      // still waiting for the transfer
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      op_i <= c.op; char_in_i <= c.ch; start_a_i <= c.sa; end_a_i <= c.ea;
      start_b_i <= c.sb; end_b_i <= c.eb; hash_a_i <= c.ha; hash_b_i <= c.hb;
      length_b_i <= c.lb;
      gap_left = c.gap;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int gen_len = 0;    // string length as seen by the queued stream
  int cmd_cnt = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [HW-1:0] rand_hash();
    if ($urandom_range(0, 15) == 0) return MOD61;
    return HW'({$urandom, $urandom});
  endfunction

  task automatic put(input logic [2:0] op, input logic [7:0] ch, input int sa, input int ea,
                     input int sb, input int eb, input logic [HW-1:0] ha,
                     input logic [HW-1:0] hb, input int lb);
    cmd_t c;
    c.op = op; c.ch = ch; c.sa = IDX_W'(sa); c.ea = IDX_W'(ea); c.sb = IDX_W'(sb);
    c.eb = IDX_W'(eb); c.ha = ha; c.hb = hb; c.lb = IDX_W'(lb); c.gap = pick_gap();
    pending_cmds.push_back(c);
    cmd_cnt++;
    if (op == m61h_pkg::OP_CLEAR) gen_len = 0;
    else if (op == m61h_pkg::OP_APPEND && gen_len < STR_CAP) gen_len++;
  endtask

  // Sender holds off until the engine has answered everything.
  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [HW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Periodic string from a small alphabet so that common prefixes get long.
  task automatic build_string(input int n, input int period);
    logic [7:0] pat[4];
    for (int i = 0; i < 4; i++) pat[i] = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'(8'h61 + i);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) put(m61h_pkg::OP_APPEND, 8'($urandom), 0, 0, 0, 0, 0, 0, 0);
      else put(m61h_pkg::OP_APPEND, pat[i % period], 0, 0, 0, 0, 0, 0, 0);
    end
  endtask

  task automatic query_mix(input int n, input int period);
    int l, r, l2, r2, k, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      l = $urandom_range(0, gen_len);
      r = $urandom_range(l, gen_len);
      if (sel < 30) begin
        put(m61h_pkg::OP_RANGE, 8'($urandom), l, r, $urandom, $urandom, rand_hash(),
            rand_hash(), $urandom);
      end else if (sel < 50) begin
        put(m61h_pkg::OP_JOIN, 8'($urandom), $urandom, $urandom, $urandom, $urandom,
            rand_hash(), rand_hash(), $urandom_range(0, gen_len));
      end else if (sel < 85) begin
        k = $urandom_range(0, 3) * period;
        l2 = (l + k <= gen_len) ? l + k : $urandom_range(0, gen_len);
        r2 = $urandom_range(l2, gen_len);
        if ($urandom_range(0, 1)) put(m61h_pkg::OP_LCP, 8'($urandom), l, r, l2, r2,
                                      rand_hash(), rand_hash(), $urandom);
        else put(m61h_pkg::OP_LCP, 8'($urandom), l2, r2, l, r, rand_hash(), rand_hash(),
                 $urandom);
      end else begin
        // noise: full-width fields, mostly rejected
        put(3'($urandom), 8'($urandom), $urandom_range(0, 2047), $urandom_range(0, 2047),
            $urandom_range(0, 2047), $urandom_range(0, 2047), rand_hash(), rand_hash(),
            $urandom_range(0, 2047));
      end
    end
  endtask

  initial begin
    int period, phase;
    logic [HW-1:0] bases[4];
    bases[0] = 61'd2; bases[1] = BASE_MAX; bases[2] = MOD61; bases[3] = BASE_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every op, rejects, hash inputs equal to P
    put(m61h_pkg::OP_RANGE, 0, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_APPEND, 8'h00, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_APPEND, 8'hff, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_APPEND, 8'h80, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_APPEND, 8'hff, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 0, 4, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 1, 3, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 3, 2, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 0, 5, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 2047, 2047, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_JOIN, 0, 0, 0, 0, 0, MOD61, MOD61, 4);
    put(m61h_pkg::OP_JOIN, 0, 0, 0, 0, 0, BASE_MAX, BASE_MAX, 0);
    put(m61h_pkg::OP_JOIN, 0, 0, 0, 0, 0, 61'd1, 61'd2, 5);
    put(m61h_pkg::OP_LCP, 0, 0, 4, 0, 4, 0, 0, 0);
    put(m61h_pkg::OP_LCP, 0, 1, 2, 3, 4, 0, 0, 0);
    put(m61h_pkg::OP_LCP, 0, 0, 4, 3, 2, 0, 0, 0);
    put(m61h_pkg::OP_LCP, 0, 0, 4, 0, 2047, 0, 0, 0);
    put(OP_BAD_5, 8'hff, 1, 1, 1, 1, MOD61, MOD61, 1);
    put(OP_BAD_6, 0, 0, 0, 0, 0, 0, 0, 0);
    put(OP_BAD_7, 0, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 0, 1, 0, 0, 0, 0, 0);

    // Base change after a clear: one append, then a query of that entry
    write_base(BASE_MAX);
    put(m61h_pkg::OP_APPEND, 8'h11, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 0, 1, 0, 0, 0, 0, 0);

    // Full string, appends past capacity, largest ranges
    write_base(HW'($urandom_range(2, 1000)));
    put(m61h_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    build_string(STR_CAP, 2);
    put(m61h_pkg::OP_APPEND, 8'h55, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_APPEND, 8'h00, 0, 0, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_RANGE, 0, 0, STR_CAP, 0, 0, 0, 0, 0);
    put(m61h_pkg::OP_JOIN, 0, 0, 0, 0, 0, rand_hash(), rand_hash(), STR_CAP);
    put(m61h_pkg::OP_JOIN, 0, 0, 0, 0, 0, rand_hash(), rand_hash(), STR_CAP + 1);
    put(m61h_pkg::OP_LCP, 0, 0, STR_CAP, 0, STR_CAP, 0, 0, 0);
    put(m61h_pkg::OP_LCP, 0, 0, STR_CAP, 2, STR_CAP, 0, 0, 0);
    put(m61h_pkg::OP_LCP, 0, 0, STR_CAP, STR_CAP, STR_CAP, 0, 0, 0);
    query_mix(10, 2);

    // Random phases on short strings, base changed now and then
    phase = 0;
    while (cmd_cnt < 1200) begin
      if (phase % 3 == 0) begin
        if (phase / 3 < 4) write_base(bases[phase / 3]);
        else write_base(HW'({$urandom, $urandom} % MOD61));
      end
      period = $urandom_range(1, 4);
      if ($urandom_range(0, 3) != 0) put(m61h_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      build_string($urandom_range(1, 40), period);
      query_mix($urandom_range(10, 40), period);
      phase++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    power_tab[0] = 61'd1;
    prefix_tab[0] = '0;
  end

endmodule
